FILE: rtl/gpm_pkg.sv
`default_nettype none
package gpm_pkg;

	// Request codes
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_TEXT   = 2'd1;
	localparam logic [1:0] REQ_PROBE  = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	// Position roles, outside and inside a bracket class
	localparam logic [3:0] ROLE_LIT      = 4'd0;
	localparam logic [3:0] ROLE_ESC      = 4'd1;
	localparam logic [3:0] ROLE_ESC_TAIL = 4'd2;
	localparam logic [3:0] ROLE_ANY      = 4'd3;
	localparam logic [3:0] ROLE_STAR     = 4'd4;
	localparam logic [3:0] ROLE_CLASS    = 4'd5;
	localparam logic [3:0] ROLE_C_NEG    = 4'd6;
	localparam logic [3:0] ROLE_C_LIT    = 4'd7;
	localparam logic [3:0] ROLE_C_ESC    = 4'd8;
	localparam logic [3:0] ROLE_C_ETAIL  = 4'd9;
	localparam logic [3:0] ROLE_C_LO     = 4'd10;
	localparam logic [3:0] ROLE_C_DASH   = 4'd11;
	localparam logic [3:0] ROLE_C_HI     = 4'd12;
	localparam logic [3:0] ROLE_C_CLOSE  = 4'd13;

	// Pattern metacharacters
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_QUERY = 8'h3f;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_DASH  = 8'h2d;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] byte_value;
		logic       last;
	} req_t;

	typedef struct packed {
		logic matched;
		logic status;
	} res_t;

	typedef struct packed {
		logic case_insensitive;
	} cfg_t;

	function automatic logic [7:0] to_lower(input logic [7:0] x);
		return (x >= 8'd65 && x <= 8'd90) ? x + 8'd32 : x;
	endfunction

	function automatic logic lit_eq(input logic [7:0] a, input logic [7:0] c, input logic nc);
		return nc ? (to_lower(a) == to_lower(c)) : (a == c);
	endfunction

	// Range test on signed bytes: order the ends, then fold case if asked
	function automatic logic range_hit(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic nc);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] v;
		lo = ($signed(a) > $signed(b)) ? b : a;
		hi = ($signed(a) > $signed(b)) ? a : b;
		v  = c;
		if (nc) begin
			lo = to_lower(lo);
			hi = to_lower(hi);
			v  = to_lower(v);
		end
		return ($signed(v) >= $signed(lo)) && ($signed(v) <= $signed(hi));
	endfunction

	function automatic logic role_in_class(input logic [3:0] r);
		return (r >= ROLE_CLASS) && (r <= ROLE_C_CLOSE);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/gpm_chan_if.sv
`default_nettype none
interface gpm_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/gpm_seg_scan.sv
`default_nettype none
// Segmented OR prefix scan: each output ORs the inputs back to the nearest head
module gpm_seg_scan #(
	parameter int N = 64
) (
	input  wire logic [N-1:0] head,
	input  wire logic [N-1:0] val,
	output logic [N-1:0]      res
);
	localparam int L = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] h_l [L+1];
	logic [N-1:0] v_l [L+1];

	assign h_l[0] = head;
	assign v_l[0] = val;

	for (genvar k = 0; k < L; k++) begin : g_lvl
		for (genvar i = 0; i < N; i++) begin : g_el
			if (i >= (1 << k)) begin : g_comb
				assign h_l[k+1][i] = h_l[k][i] | h_l[k][i-(1<<k)];
				assign v_l[k+1][i] = h_l[k][i] ? v_l[k][i] : (v_l[k][i] | v_l[k][i-(1<<k)]);
			end else begin : g_copy
				assign h_l[k+1][i] = h_l[k][i];
				assign v_l[k+1][i] = v_l[k][i];
			end
		end
	end

	assign res = v_l[L];
endmodule
`default_nettype wire

FILE: rtl/gpm_tokenizer.sv
`default_nettype none
// Pattern store with incremental role assignment
module gpm_tokenizer #(
	parameter int W  = 64,
	parameter int LW = $clog2(W + 1)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         app_en,
	input  wire logic         clr_en,
	input  wire logic [7:0]   app_byte,
	output logic [7:0]        bytes [W],
	output logic [3:0]        roles [W],
	output logic [LW-1:0]     len,
	output logic              ovf
);
	localparam logic [2:0] ST_OUT     = 3'd0;
	localparam logic [2:0] ST_OUT_BS  = 3'd1;
	localparam logic [2:0] ST_CL_OPEN = 3'd2;
	localparam logic [2:0] ST_CL      = 3'd3;
	localparam logic [2:0] ST_CL_BS   = 3'd4;
	localparam logic [2:0] ST_CL_M1   = 3'd5;
	localparam logic [2:0] ST_CL_M2   = 3'd6;

	logic [2:0]    st_q, st_d;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic [7:0]    bytes_q [W];
	logic [3:0]    roles_q [W];
	logic [3:0]    role_new, role_r1, role_r2;
	logic          wr_r1, wr_r2, do_wr;

	assign do_wr = app_en && !ovf_q && (len_q < LW'(W));

	// Role of the new byte and rewrites of the one or two before it
	always_comb begin
		st_d     = st_q;
		role_new = gpm_pkg::ROLE_LIT;
		role_r1  = gpm_pkg::ROLE_LIT;
		role_r2  = gpm_pkg::ROLE_LIT;
		wr_r1    = 1'b0;
		wr_r2    = 1'b0;
		case (st_q)
			ST_OUT: begin
				if (app_byte == gpm_pkg::CH_STAR) begin
					role_new = gpm_pkg::ROLE_STAR;
				end else if (app_byte == gpm_pkg::CH_QUERY) begin
					role_new = gpm_pkg::ROLE_ANY;
				end else if (app_byte == gpm_pkg::CH_LBRK) begin
					role_new = gpm_pkg::ROLE_CLASS;
					st_d     = ST_CL_OPEN;
				end else if (app_byte == gpm_pkg::CH_BSL) begin
					st_d = ST_OUT_BS;
				end
			end
			ST_OUT_BS: begin
				role_r1  = gpm_pkg::ROLE_ESC;
				wr_r1    = 1'b1;
				role_new = gpm_pkg::ROLE_ESC_TAIL;
				st_d     = ST_OUT;
			end
			ST_CL_BS: begin
				role_r1  = gpm_pkg::ROLE_C_ESC;
				wr_r1    = 1'b1;
				role_new = gpm_pkg::ROLE_C_ETAIL;
				st_d     = ST_CL;
			end
			ST_CL_M2: begin
				role_r2  = gpm_pkg::ROLE_C_LO;
				wr_r2    = 1'b1;
				role_r1  = gpm_pkg::ROLE_C_DASH;
				wr_r1    = 1'b1;
				role_new = gpm_pkg::ROLE_C_HI;
				st_d     = ST_CL;
			end
			ST_CL_OPEN, ST_CL, ST_CL_M1: begin
				if (st_q == ST_CL_OPEN && app_byte == gpm_pkg::CH_CARET) begin
					role_new = gpm_pkg::ROLE_C_NEG;
					st_d     = ST_CL;
				end else if (st_q == ST_CL_M1 && app_byte == gpm_pkg::CH_DASH) begin
					role_new = gpm_pkg::ROLE_C_LIT;
					st_d     = ST_CL_M2;
				end else if (app_byte == gpm_pkg::CH_BSL) begin
					role_new = gpm_pkg::ROLE_C_LIT;
					st_d     = ST_CL_BS;
				end else if (app_byte == gpm_pkg::CH_RBRK) begin
					role_new = gpm_pkg::ROLE_C_CLOSE;
					st_d     = ST_OUT;
				end else begin
					role_new = gpm_pkg::ROLE_C_LIT;
					st_d     = ST_CL_M1;
				end
			end
			default: begin
				st_d = ST_OUT;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_OUT;
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (clr_en) begin
			st_q  <= ST_OUT;
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (app_en) begin
			if (do_wr) begin
				st_q  <= st_d;
				len_q <= len_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Pattern bytes and roles
	for (genvar i = 0; i < W; i++) begin : g_ent
		always_ff @(posedge clk) begin
			if (do_wr) begin
				if ((LW+1)'(i) == {1'b0, len_q}) begin
					bytes_q[i] <= app_byte;
					roles_q[i] <= role_new;
				end
				if (wr_r1 && (LW+1)'(i + 1) == {1'b0, len_q}) begin
					roles_q[i] <= role_r1;
				end
				if (wr_r2 && (LW+1)'(i + 2) == {1'b0, len_q}) begin
					roles_q[i] <= role_r2;
				end
			end
		end
	end

	assign bytes = bytes_q;
	assign roles = roles_q;
	assign len   = len_q;
	assign ovf   = ovf_q;
endmodule
`default_nettype wire

FILE: rtl/gpm_matcher.sv
`default_nettype none
// Active position set, advanced by one text byte per transfer
module gpm_matcher #(
	parameter int W  = 64,
	parameter int LW = $clog2(W + 1)
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step_en,
	input  wire logic         kill,
	input  wire logic         last,
	input  wire logic [7:0]   c,
	input  wire logic         nc,
	input  wire logic [7:0]   bytes [W],
	input  wire logic [3:0]   roles [W],
	input  wire logic [LW-1:0] len,
	output logic              hit_end
);
	logic [W:0]   act_q;
	logic         tip_q;
	logic [W-1:0] valid, star, adv, inclass, cont, tail;
	logic [W-1:0] c_head, c_a, c_n, c_h, s_a, s_n, s_h;
	logic [W:0]   i_head, i_val, i_cl, cur, n_head, nxt, new_act;

	for (genvar p = 0; p < W; p++) begin : g_pos
		assign valid[p]   = LW'(p) < len;
		assign star[p]    = valid[p] && roles[p] == gpm_pkg::ROLE_STAR;
		assign inclass[p] = valid[p] && gpm_pkg::role_in_class(roles[p]);
		assign cont[p]    = inclass[p] && roles[p] != gpm_pkg::ROLE_CLASS;
		assign c_head[p]  = valid[p] && roles[p] == gpm_pkg::ROLE_CLASS;
		assign c_a[p]     = c_head[p] && cur[p];
		assign c_n[p]     = valid[p] && roles[p] == gpm_pkg::ROLE_C_NEG;
		if (p + 1 < W) begin : g_tl
			assign tail[p] = inclass[p] && !cont[p+1];
		end else begin : g_tl_end
			assign tail[p] = inclass[p];
		end
		// Class member hits
		if (p + 2 < W) begin : g_rng
			assign c_h[p] = valid[p] && (
				(roles[p] == gpm_pkg::ROLE_C_LIT && gpm_pkg::lit_eq(bytes[p], c, nc)) ||
				(roles[p] == gpm_pkg::ROLE_C_ETAIL && bytes[p] == c) ||
				(roles[p] == gpm_pkg::ROLE_C_LO &&
					gpm_pkg::range_hit(bytes[p], bytes[p+2], c, nc)));
		end else begin : g_norng
			assign c_h[p] = valid[p] && (
				(roles[p] == gpm_pkg::ROLE_C_LIT && gpm_pkg::lit_eq(bytes[p], c, nc)) ||
				(roles[p] == gpm_pkg::ROLE_C_ETAIL && bytes[p] == c));
		end
		// Move to the next position on a literal, any-byte or escape token, or a class end
		if (p >= 1) begin : g_esc
			assign adv[p] = (valid[p] && roles[p] == gpm_pkg::ROLE_LIT && cur[p] &&
					gpm_pkg::lit_eq(bytes[p], c, nc)) ||
				(valid[p] && roles[p] == gpm_pkg::ROLE_ANY && cur[p]) ||
				(valid[p] && roles[p] == gpm_pkg::ROLE_ESC_TAIL && cur[p-1] &&
					gpm_pkg::lit_eq(bytes[p], c, nc)) ||
				(tail[p] && s_a[p] && (s_n[p] ^ s_h[p]));
		end else begin : g_first
			assign adv[p] = (valid[p] && roles[p] == gpm_pkg::ROLE_LIT && cur[p] &&
					gpm_pkg::lit_eq(bytes[p], c, nc)) ||
				(valid[p] && roles[p] == gpm_pkg::ROLE_ANY && cur[p]) ||
				(tail[p] && s_a[p] && (s_n[p] ^ s_h[p]));
		end
	end

	// Gather each class from its opening bracket
	gpm_seg_scan #(.N(W)) u_scan_a (.head(c_head), .val(c_a), .res(s_a));
	gpm_seg_scan #(.N(W)) u_scan_n (.head(c_head), .val(c_n), .res(s_n));
	gpm_seg_scan #(.N(W)) u_scan_h (.head(c_head), .val(c_h), .res(s_h));

	// Start set: position zero closed over the leading run of stars
	assign i_head[0] = 1'b1;
	assign i_val[0]  = 1'b1;
	assign n_head[0] = 1'b1;
	assign nxt[0]    = star[0] && cur[0];
	for (genvar p = 1; p <= W; p++) begin : g_close
		assign i_head[p] = !star[p-1];
		assign i_val[p]  = 1'b0;
		assign n_head[p] = !star[p-1];
		if (p < W) begin : g_mid
			assign nxt[p] = (star[p] && cur[p]) || adv[p-1];
		end else begin : g_top
			assign nxt[p] = adv[p-1];
		end
	end

	gpm_seg_scan #(.N(W + 1)) u_scan_init (.head(i_head), .val(i_val), .res(i_cl));
	gpm_seg_scan #(.N(W + 1)) u_scan_next (.head(n_head), .val(nxt), .res(new_act));

	assign cur     = tip_q ? act_q : i_cl;
	assign hit_end = new_act[len];

	// Hold the set between bytes of one text; drop it after the last byte or on any other request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			tip_q <= 1'b0;
		end else if (step_en) begin
			act_q <= new_act;
			tip_q <= !last;
		end else if (kill) begin
			tip_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/glob_pattern_matcher.sv
`default_nettype none
// Glob pattern matcher.
// Channel req carries requests: append a pattern byte, a text byte (last
// marks the end of the text), an empty-text probe, or clear the pattern.
// Channel res returns one result (matched, status) for each probe and for
// each text byte marked last; other requests return nothing.
// Channel cfg writes case_insensitive; write it only while the block is idle.
// A request is taken into an input register, then evaluated combinationally
// against the stored pattern and the active position set, and its result is
// written to the output register, which drives res valid.
// One request a cycle is sustained unless a result waits on a stalled res;
// the position update over MAX_PATTERN positions is combinational.
// When res is stalled with a result waiting, requests that give no result
// still go through; one that gives a result waits in the input register,
// and req.ready falls until the output register is taken.
// Reset empties the pattern, clears overflow, case folding and any text in
// progress; no clearing pass is needed.
module glob_pattern_matcher #(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	gpm_chan_if.sink    req,
	gpm_chan_if.source  res,
	gpm_chan_if.sink    cfg
);
	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic             valid_s1;
	gpm_pkg::req_t    item_s1;
	logic             nc_q;
	logic             out_valid_q;
	gpm_pkg::res_t    out_q;
	logic             gives_res, advance;
	logic             match_bit, ovf;
	logic [LW-1:0]    len;
	logic [7:0]       bytes [MAX_PATTERN];
	logic [3:0]       roles [MAX_PATTERN];

	assign gives_res = (item_s1.req_type == gpm_pkg::REQ_PROBE) ||
		(item_s1.req_type == gpm_pkg::REQ_TEXT && item_s1.last);
	assign advance   = valid_s1 && (!gives_res || !out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= 1'b0;
		end else if (cfg.valid) begin
			nc_q <= cfg.data.case_insensitive;
		end
	end

	gpm_tokenizer #(.W(MAX_PATTERN), .LW(LW)) u_tok (
		.clk      (clk),
		.arst_n   (arst_n),
		.app_en   (advance && item_s1.req_type == gpm_pkg::REQ_APPEND),
		.clr_en   (advance && item_s1.req_type == gpm_pkg::REQ_CLEAR),
		.app_byte (item_s1.byte_value),
		.bytes    (bytes),
		.roles    (roles),
		.len      (len),
		.ovf      (ovf)
	);

	gpm_matcher #(.W(MAX_PATTERN), .LW(LW)) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance && item_s1.req_type == gpm_pkg::REQ_TEXT),
		.kill    (advance && item_s1.req_type != gpm_pkg::REQ_TEXT),
		.last    (item_s1.last),
		.c       (item_s1.byte_value),
		.nc      (nc_q),
		.bytes   (bytes),
		.roles   (roles),
		.len     (len),
		.hit_end (match_bit)
	);

	// Output register: load on a result, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && gives_res) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gives_res) begin
			out_q.status <= ovf;
			if (item_s1.req_type == gpm_pkg::REQ_PROBE) begin
				out_q.matched <= !ovf && (len == '0);
			end else begin
				out_q.matched <= !ovf && match_bit;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;
endmodule
`default_nettype wire
